// ----- hw/rtl/ttm_pkg.sv -----
// ----------------------------------------------------------------------------
// ttm_pkg
// Types and constants shared by the throttle tracking model.
// ----------------------------------------------------------------------------
package ttm_pkg;

  localparam int unsigned SCALE_NUM  = 20000;      // full scale of scaled positions
  localparam int unsigned RAW_SCALE  = 4095;       // raw full scale
  localparam int unsigned GAIN_DIV   = 200;
  localparam int unsigned GAIN_RECIP = 10737418;   // floor(2^31 / 200)
  localparam int unsigned GAIN_SHIFT = 31;
  localparam int unsigned EST_SHIFT  = 24;         // 4097 / 2^24 ~ 1 / 4095
  localparam int unsigned RAW_SHIFT  = 12;

  localparam logic [15:0]        UNSEEDED     = 16'hFFFF;
  localparam logic signed [17:0] FULL_SCALE_S = 18'sd20000;
  localparam logic signed [17:0] LARGE_ERR_S  = 18'sd200;
  localparam logic signed [17:0] RATE_MAX_S   = 18'sd32767;
  localparam logic signed [17:0] RATE_MIN_S   = -18'sd32768;

  typedef enum logic [2:0] {
    REG_OPEN_GAIN        = 3'd0,
    REG_CLOSE_GAIN       = 3'd1,
    REG_OPEN_RATE_LIMIT  = 3'd2,
    REG_CLOSE_RATE_LIMIT = 3'd3,
    REG_SLOW_RISE_STEP   = 3'd4,
    REG_SLOW_FALL_STEP   = 3'd5,
    REG_FAST_FALL_STEP   = 3'd6,
    REG_FAST_RISE_STEP   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  open_gain;
    logic [7:0]  close_gain;
    logic [14:0] open_rate_limit;
    logic [14:0] close_rate_limit;
    logic [7:0]  slow_rise_step;
    logic [7:0]  slow_fall_step;
    logic [7:0]  fast_fall_step;
    logic [7:0]  fast_rise_step;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCL_MUL,
    OP_SCL_EST,
    OP_SCL_FIX,
    OP_ERR_MUL,
    OP_DIV_MUL,
    OP_DIV_FIX,
    OP_SLEW,
    OP_POS
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel_fb;   // scaling step works on the feedback channel
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_C,
    S_EST_C,
    S_FIX_C,
    S_MUL_F,
    S_EST_F,
    S_FIX_F,
    S_ERR,
    S_DMUL,
    S_DFIX,
    S_SLEW,
    S_POS
  } state_t;

endpackage

// ----- hw/rtl/ttm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttm_ctrl
// Sequencer: steps one tick through the shared datapath, owns the result
// word handshake.
// ----------------------------------------------------------------------------
module ttm_ctrl
  import ttm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fire_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = OP_NONE;
    cmd.sel_fb = 1'b0;
    in_tready  = 1'b0;
    fire_pos   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MUL_C;
        end
      end
      S_MUL_C: begin
        cmd.op    = OP_SCL_MUL;
        state_nxt = S_EST_C;
      end
      S_EST_C: begin
        cmd.op    = OP_SCL_EST;
        state_nxt = S_FIX_C;
      end
      S_FIX_C: begin
        cmd.op    = OP_SCL_FIX;
        state_nxt = S_MUL_F;
      end
      S_MUL_F: begin
        cmd.op     = OP_SCL_MUL;
        cmd.sel_fb = 1'b1;
        state_nxt  = S_EST_F;
      end
      S_EST_F: begin
        cmd.op    = OP_SCL_EST;
        state_nxt = S_FIX_F;
      end
      S_FIX_F: begin
        cmd.op     = OP_SCL_FIX;
        cmd.sel_fb = 1'b1;
        state_nxt  = S_ERR;
      end
      S_ERR: begin
        cmd.op    = OP_ERR_MUL;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        cmd.op    = OP_DIV_MUL;
        state_nxt = S_DFIX;
      end
      S_DFIX: begin
        cmd.op    = OP_DIV_FIX;
        state_nxt = S_SLEW;
      end
      S_SLEW: begin
        cmd.op    = OP_SLEW;
        state_nxt = S_POS;
      end
      S_POS: begin
        if (!out_valid_r || out_tready) begin
          cmd.op    = OP_POS;
          fire_pos  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (fire_pos) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- hw/rtl/ttm_datapath.sv -----
// ----------------------------------------------------------------------------
// ttm_datapath
// Scaling, target rate, slewing and position integration around one shared
// multiplier; holds the model state and the result word.
// ----------------------------------------------------------------------------
module ttm_datapath
  import ttm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic [11:0]        command_raw,
  input  logic [11:0]        feedback_raw,
  output logic [14:0]        command_scaled,
  output logic [14:0]        feedback_scaled,
  output logic [14:0]        model_position,
  output logic signed [15:0] model_rate
);

  logic [11:0]        raw_c_r, raw_f_r;
  logic [26:0]        prod_r;
  logic [14:0]        q_r;
  logic [14:0]        cmd_s_r, fb_s_r;
  logic [15:0]        pos_r;
  logic signed [15:0] rate_r;
  logic               open_r;
  logic signed [17:0] target_r;
  logic [14:0]        o_cmd_r, o_fb_r, o_pos_r;
  logic signed [15:0] o_rate_r;

  // shared multiplier
  logic [23:0] mul_a, mul_b;
  logic [47:0] mul_p;

  logic signed [16:0] diff;
  logic               is_open;
  logic [14:0]        diff_mag;
  logic [7:0]         gain;

  logic [39:0] est_sum;
  logic [26:0] q_x4095, rem_s;
  logic [14:0] scl;

  logic [22:0] q_x200, rem_g;
  logic [14:0] tmag, lim, tclamp;
  logic signed [17:0] target;

  logic signed [17:0] r18, step18, d18, amt18, rnew18;
  logic               small_err, fall;
  logic [7:0]         step_sel;
  logic signed [15:0] rate_new;

  logic signed [17:0] np18;
  logic [14:0]        pos_new;

  assign diff     = $signed({2'b00, cmd_s_r}) - $signed({2'b00, pos_r[14:0]});
  assign is_open  = (diff > 17'sd0);
  assign diff_mag = diff[16] ? 15'(-diff) : diff[14:0];
  assign gain     = is_open ? cfg.open_gain : cfg.close_gain;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SCL_MUL: begin
        mul_a = {12'b0, (cmd.sel_fb ? raw_f_r : raw_c_r)};
        mul_b = 24'(SCALE_NUM);
      end
      OP_ERR_MUL: begin
        mul_a = {9'b0, diff_mag};
        mul_b = {16'b0, gain};
      end
      OP_DIV_MUL: begin
        mul_a = {1'b0, prod_r[22:0]};
        mul_b = 24'(GAIN_RECIP);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {24'b0, mul_a} * {24'b0, mul_b};

  // raw * 20000 / 4095: estimate by 4097 / 2^24, then one correction
  assign est_sum = ({13'b0, prod_r} << RAW_SHIFT) + {13'b0, prod_r};
  assign q_x4095 = ({12'b0, q_r} << RAW_SHIFT) - {12'b0, q_r};
  assign rem_s   = prod_r - q_x4095;
  assign scl     = q_r + {14'b0, (rem_s >= 27'(RAW_SCALE))};

  // |gain * err| / 200: estimate by reciprocal, then one correction
  assign q_x200 = ({8'b0, q_r} << 7) + ({8'b0, q_r} << 6) + ({8'b0, q_r} << 3);
  assign rem_g  = prod_r[22:0] - q_x200;
  assign tmag   = q_r + {14'b0, (rem_g >= 23'(GAIN_DIV))};
  assign lim    = open_r ? cfg.open_rate_limit : cfg.close_rate_limit;
  assign tclamp = (tmag > lim) ? lim : tmag;
  assign target = open_r ? $signed({3'b000, tclamp}) : -$signed({3'b000, tclamp});

  // rate slewing
  assign r18       = {{2{rate_r[15]}}, rate_r};
  assign small_err = ((r18 > 18'sd0) && (r18 > target_r)) ||
                     ((r18 < 18'sd0) && (target_r > r18)) ||
                     ((r18 > -LARGE_ERR_S) && (r18 < LARGE_ERR_S));
  assign fall      = (target_r < r18);
  always_comb begin
    if (fall) begin
      step_sel = small_err ? cfg.slow_fall_step : cfg.fast_fall_step;
    end else begin
      step_sel = small_err ? cfg.slow_rise_step : cfg.fast_rise_step;
    end
  end
  assign step18 = $signed({9'b0, step_sel, 1'b0});
  assign d18    = fall ? (r18 - target_r) : (target_r - r18);
  assign amt18  = (d18 > step18) ? step18 : d18;
  assign rnew18 = fall ? (r18 - amt18) : (r18 + amt18);
  always_comb begin
    if (rnew18 > RATE_MAX_S) begin
      rate_new = 16'sh7FFF;
    end else if (rnew18 < RATE_MIN_S) begin
      rate_new = 16'sh8000;
    end else begin
      rate_new = rnew18[15:0];
    end
  end

  // position integration
  assign np18 = $signed({3'b000, pos_r[14:0]}) + r18;
  always_comb begin
    if (np18 > FULL_SCALE_S) begin
      pos_new = 15'(SCALE_NUM);
    end else if (np18 < 18'sd0) begin
      pos_new = '0;
    end else begin
      pos_new = np18[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= UNSEEDED;
      rate_r <= '0;
    end else begin
      case (cmd.op)
        OP_SCL_FIX: begin
          if (cmd.sel_fb && (pos_r == UNSEEDED)) begin
            pos_r <= {1'b0, scl};
          end
        end
        OP_SLEW: rate_r <= rate_new;
        OP_POS:  pos_r  <= {1'b0, pos_new};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        raw_c_r <= command_raw;
        raw_f_r <= feedback_raw;
      end
      OP_SCL_MUL: prod_r <= mul_p[26:0];
      OP_SCL_EST: q_r    <= est_sum[38:24];
      OP_SCL_FIX: begin
        if (cmd.sel_fb) begin
          fb_s_r <= scl;
        end else begin
          cmd_s_r <= scl;
        end
      end
      OP_ERR_MUL: begin
        prod_r <= mul_p[26:0];
        open_r <= is_open;
      end
      OP_DIV_MUL: q_r      <= mul_p[GAIN_SHIFT +: 15];
      OP_DIV_FIX: target_r <= target;
      OP_POS: begin
        o_cmd_r  <= cmd_s_r;
        o_fb_r   <= fb_s_r;
        o_pos_r  <= pos_new;
        o_rate_r <= rate_r;
      end
      default: ;
    endcase
  end

  assign command_scaled  = o_cmd_r;
  assign feedback_scaled = o_fb_r;
  assign model_position  = o_pos_r;
  assign model_rate      = o_rate_r;

endmodule

// ----- hw/rtl/throttle_tracking_model.sv -----
// ----------------------------------------------------------------------------
// throttle_tracking_model
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// One word in, one word out per tick. The result word is registered after
// the sequencer has walked the datapath through two scalings (three steps
// each), the gain product, the divide by 200 (two steps) and the slew and
// integrate steps, all on one shared 24x24 multiplier. The block takes a
// new word in the cycle after the integrate step and takes none while a
// tick is in work. The integrate step waits while an earlier result word
// is still held in the output register, which stalls the input for as
// long as the result side is stalled. Configuration writes are always
// taken and should be made while the block is idle.
// ----------------------------------------------------------------------------
module throttle_tracking_model
  import ttm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command_raw[11:0], feedback_raw[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // command_scaled[14:0], feedback_scaled[29:15],
                                  // model_position[44:30], model_rate[60:45]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  cfg_t               cfg_r;
  cmd_t               cmd;
  logic [14:0]        command_scaled, feedback_scaled, model_position;
  logic signed [15:0] model_rate;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_OPEN_GAIN:        cfg_r.open_gain        <= cfg_data[7:0];
        REG_CLOSE_GAIN:       cfg_r.close_gain       <= cfg_data[7:0];
        REG_OPEN_RATE_LIMIT:  cfg_r.open_rate_limit  <= cfg_data;
        REG_CLOSE_RATE_LIMIT: cfg_r.close_rate_limit <= cfg_data;
        REG_SLOW_RISE_STEP:   cfg_r.slow_rise_step   <= cfg_data[7:0];
        REG_SLOW_FALL_STEP:   cfg_r.slow_fall_step   <= cfg_data[7:0];
        REG_FAST_FALL_STEP:   cfg_r.fast_fall_step   <= cfg_data[7:0];
        REG_FAST_RISE_STEP:   cfg_r.fast_rise_step   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ttm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ttm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg_r),
    .command_raw     (in_tdata[11:0]),
    .feedback_raw    (in_tdata[23:12]),
    .command_scaled  (command_scaled),
    .feedback_scaled (feedback_scaled),
    .model_position  (model_position),
    .model_rate      (model_rate)
  );

  assign out_tdata = {3'b000, model_rate, model_position, feedback_scaled, command_scaled};

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44:30] <= 15'd20000))
    else $error("model position above full scale");

  a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (($signed(out_tdata[60:45]) <= 16'sd25500) &&
                    ($signed(out_tdata[60:45]) >= -16'sd25500)))
    else $error("model rate outside slew range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while a tick is in work");

endmodule
